// File: src/tpd_pkg.sv
package tpd_pkg;

  localparam int FRAME_BYTES     = 188;
  localparam int SLOT_BYTES      = 46;
  localparam int SLOTS_PER_FRAME = 4;
  localparam int PKT_BYTES       = 42;
  localparam int ID_OFFSET       = 4;
  localparam int PKT_OFFSET      = 8;
  localparam int HDR_BYTES       = 8;
  localparam int LAST_ROW        = 23;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [7:0] ID_SUBTITLE_A = 8'h02;
  localparam logic [7:0] ID_SUBTITLE_B = 8'h03;
  localparam logic [7:0] UNITS_INVALID = 8'hff;
  localparam logic [7:0] UNITS_MAX_DEC = 8'h99;
  localparam logic [3:0] DIGIT_MAX     = 4'd9;
  localparam logic [4:0] ROW_IGNORE    = 5'h1f;
  localparam logic [3:0] MAG_EIGHT     = 4'd8;

  typedef enum logic [1:0] {
    KIND_ROW   = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_END  = 2'd0,
    OP_DATA = 2'd1,
    OP_HDR  = 2'd2
  } op_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } frame_t;

  typedef struct packed {
    logic [2:0]  language;
    logic [7:0]  page_flags;
    logic [13:0] subpage;
    logic [7:0]  page_units;
    logic [2:0]  magazine;
  } page_info_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  magazine;
    logic [11:0] page_number;
    logic [7:0]  page_units;
    logic [13:0] subpage;
    logic [7:0]  page_flags;
    logic [2:0]  language;
    logic [4:0]  row;
    logic [5:0]  column;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  // One queued job: page end, row byte, or header open (start + 8 bytes if kept)
  typedef struct packed {
    op_t                         op;
    page_info_t                  info;
    logic                        kept;
    logic [4:0]                  row;
    logic [5:0]                  column;
    logic [7:0]                  data_byte;
    logic [HDR_BYTES-1:0][7:0]   hdr;
  } cmd_t;

  typedef struct packed {
    logic [2:0] quot;
    logic [5:0] rem;
  } slot_pos_t;

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] ham_encode(input logic [3:0] n);
    logic [7:0] c;
    c[0] = ~(n[0] ^ n[2] ^ n[3]);
    c[1] = n[0];
    c[2] = ~(n[0] ^ n[1] ^ n[3]);
    c[3] = n[1];
    c[4] = ~(n[0] ^ n[1] ^ n[2]);
    c[5] = n[2];
    c[6] = 1'b0;
    c[7] = n[3];
    c[6] = ~(^c);
    return c;
  endfunction

  // First codeword within one bit wins; two bit errors give 0xF
  function automatic logic [3:0] ham_decode(input logic [7:0] b);
    logic [3:0] d;
    logic       found;
    logic [7:0] x;
    d     = 4'hf;
    found = 1'b0;
    for (int n = 0; n < 16; n++) begin
      x = ham_encode(4'(n)) ^ b;
      if (!found && ((x & (x - 8'd1)) == 8'd0)) begin
        d     = 4'(n);
        found = 1'b1;
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] ham_pair(input logic [7:0] lo, input logic [7:0] hi);
    return {ham_decode(hi), ham_decode(lo)};
  endfunction

  // Split an offset into slot index and offset inside the slot
  function automatic slot_pos_t slot_split(input logic [7:0] v);
    slot_pos_t  p;
    logic [7:0] r;
    logic [2:0] q;
    r = v;
    q = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (r >= 8'(SLOT_BYTES)) begin
        r = r - 8'(SLOT_BYTES);
        q = q + 3'd1;
      end
    end
    p.quot = q;
    p.rem  = r[5:0];
    return p;
  endfunction

endpackage

// File: src/tpd_stream_if.sv
interface tpd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/teletext_packet_page_decoder.sv
// channel      dir  payload                                   handshake
// frame_in     in   frame_byte, frame_start                   valid/ready
// result_out   out  kind, page fields, row, column, data,last valid/ready
// cfg          in   store_top_text                            cfg_we, no ready
//
// One frame byte per cycle. Each byte queues at most one job; a header open
// job gives a start word plus, if kept, 8 header bytes, one registered output
// word per cycle unless stalled. Input stalls only on a full 4-entry queue.
// rst is synchronous and clears all control state; no memory clearing pass.
module teletext_packet_page_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  tpd_stream_if.sink   frame_in,
  tpd_stream_if.source result_out
);
  import tpd_pkg::*;

  logic fifo_full;
  logic fifo_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  tpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .frame_in  (frame_in),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tpd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (fifo_full),
    .empty    (fifo_empty),
    .head     (head)
  );

  tpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (fifo_empty),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

// File: src/tpd_front.sv
module tpd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  tpd_stream_if.sink    frame_in,
  input  logic          fifo_full,
  output logic          push,
  output tpd_pkg::cmd_t push_cmd
);
  import tpd_pkg::*;

  logic             store_top_text;
  logic [7:0]       byte_position, byte_position_next;
  logic             slot_active, slot_active_next;
  logic [3:0]       addr_nibble, addr_nibble_next;
  logic [4:0]       packet_row, packet_row_next;
  logic [2:0]       packet_magazine, packet_magazine_next;
  logic [7:0]       header_bytes [HDR_BYTES];
  logic [7:0]       header_bytes_next [HDR_BYTES];
  logic             page_open, page_open_next;
  logic             page_kept, page_kept_next;
  page_info_t       open_page_info, open_page_info_next;

  logic             accept;
  logic [7:0]       pos;
  logic             sa;
  logic [7:0]       rev;
  logic [7:0]       rel;
  slot_pos_t        sp;
  slot_pos_t        rp;
  logic [5:0]       col;
  logic [7:0]       addr_word;
  logic [7:0]       b1, b2, b3, b4;
  logic [7:0]       flags;
  logic             top_page;
  page_info_t       new_info;

  assign frame_in.ready = !fifo_full;
  assign accept         = frame_in.valid && !fifo_full;

  always_comb begin
    byte_position_next   = byte_position;
    slot_active_next     = slot_active;
    addr_nibble_next     = addr_nibble;
    packet_row_next      = packet_row;
    packet_magazine_next = packet_magazine;
    header_bytes_next    = header_bytes;
    page_open_next       = page_open;
    page_kept_next       = page_kept;
    open_page_info_next  = open_page_info;
    push                 = 1'b0;
    push_cmd             = '0;

    pos  = frame_in.data.frame_start ? 8'd0 : byte_position;
    sa   = frame_in.data.frame_start ? 1'b0 : slot_active;
    rev  = bit_rev(frame_in.data.frame_byte);
    rel  = pos - 8'(PKT_OFFSET);
    sp   = slot_split(pos);
    rp   = slot_split(rel);
    col  = rp.rem - 6'd2;

    addr_word = {ham_decode(rev), addr_nibble};

    // header decode, valid when the eighth header byte is the current one
    b1 = ham_pair(header_bytes[0], header_bytes[1]);
    b2 = ham_pair(header_bytes[2], header_bytes[3]);
    b3 = ham_pair(header_bytes[4], header_bytes[5]);
    b4 = ham_pair(header_bytes[6], rev);
    flags = {b2[7], b3[6], b3[7], b4[0], b4[1], b4[2], b4[2], b4[4]};
    top_page = (b1 > UNITS_MAX_DEC) || (b1[3:0] > DIGIT_MAX);
    new_info.magazine   = packet_magazine;
    new_info.page_units = b1;
    new_info.subpage    = {b3[5:0], 1'b0, b2[6:0]};
    new_info.page_flags = flags;
    new_info.language   = b4[7:5];

    if (accept && pos < 8'(FRAME_BYTES)) begin
      byte_position_next = pos + 8'd1;
      slot_active_next   = sa;
      if (sp.rem == 6'(ID_OFFSET) && sp.quot < 3'(SLOTS_PER_FRAME)) begin
        slot_active_next = (frame_in.data.frame_byte == ID_SUBTITLE_A) ||
                           (frame_in.data.frame_byte == ID_SUBTITLE_B);
      end else if (pos >= 8'(PKT_OFFSET) && sa && rp.quot < 3'(SLOTS_PER_FRAME) &&
                   rp.rem < 6'(PKT_BYTES)) begin
        if (rp.rem == 6'd0) begin
          addr_nibble_next = ham_decode(rev);
        end else if (rp.rem == 6'd1) begin
          packet_magazine_next = addr_word[2:0];
          packet_row_next      = addr_word[7:3];
        end else begin
          if (col < 6'(HDR_BYTES)) begin
            header_bytes_next[col[2:0]] = rev;
          end
          if (packet_row == 5'd0) begin
            if (col == 6'd1) begin
              if (ham_pair(header_bytes[0], rev) == UNITS_INVALID) begin
                packet_row_next = ROW_IGNORE;
              end else begin
                if (page_open && page_kept) begin
                  push          = 1'b1;
                  push_cmd.op   = OP_END;
                  push_cmd.info = open_page_info;
                end
                page_open_next = 1'b0;
              end
            end else if (col == 6'(HDR_BYTES - 1)) begin
              open_page_info_next = new_info;
              page_open_next      = 1'b1;
              page_kept_next      = store_top_text || !top_page;
              push                = 1'b1;
              push_cmd.op         = OP_HDR;
              push_cmd.info       = new_info;
              push_cmd.kept       = store_top_text || !top_page;
              for (int i = 0; i < HDR_BYTES - 1; i++) begin
                push_cmd.hdr[i] = header_bytes[i];
              end
              push_cmd.hdr[HDR_BYTES-1] = rev;
            end else if (col >= 6'(HDR_BYTES) && page_open && page_kept) begin
              push               = 1'b1;
              push_cmd.op        = OP_DATA;
              push_cmd.info      = open_page_info;
              push_cmd.kept      = 1'b1;
              push_cmd.column    = col;
              push_cmd.data_byte = rev;
            end
          end else if (packet_row <= 5'(LAST_ROW) && page_open && page_kept) begin
            push               = 1'b1;
            push_cmd.op        = OP_DATA;
            push_cmd.info      = open_page_info;
            push_cmd.kept      = 1'b1;
            push_cmd.row       = packet_row;
            push_cmd.column    = col;
            push_cmd.data_byte = rev;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_top_text  <= 1'b0;
      byte_position   <= '0;
      slot_active     <= 1'b0;
      addr_nibble     <= '0;
      packet_row      <= '0;
      packet_magazine <= '0;
      page_open       <= 1'b0;
      page_kept       <= 1'b0;
      open_page_info  <= '0;
    end else begin
      if (cfg_we) begin
        store_top_text <= cfg_wdata;
      end
      byte_position   <= byte_position_next;
      slot_active     <= slot_active_next;
      addr_nibble     <= addr_nibble_next;
      packet_row      <= packet_row_next;
      packet_magazine <= packet_magazine_next;
      page_open       <= page_open_next;
      page_kept       <= page_kept_next;
      open_page_info  <= open_page_info_next;
    end
  end

  // header bytes are always written before they are read within a packet
  always_ff @(posedge clk) begin
    header_bytes <= header_bytes_next;
  end

endmodule

// File: src/tpd_cmd_fifo.sv
module tpd_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tpd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output tpd_pkg::cmd_t head
);
  import tpd_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: src/tpd_back.sv
module tpd_back (
  input  logic          clk,
  input  logic          rst,
  input  tpd_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  tpd_stream_if.source  result_out
);
  import tpd_pkg::*;

  localparam int SEQ_W = $clog2(HDR_BYTES + 1);
  localparam int IDX_W = $clog2(HDR_BYTES);

  logic [SEQ_W-1:0] seq;
  logic             out_valid;
  result_t          out_data;
  result_t          res;
  logic             final_word;
  logic             load;
  logic [IDX_W-1:0] idx;

  assign result_out.valid = out_valid;
  assign result_out.data  = out_data;

  assign load = !empty && (!out_valid || result_out.ready);
  assign pop  = load && final_word;
  assign idx  = IDX_W'(seq - SEQ_W'(1));

  always_comb begin
    res             = '0;
    res.magazine    = head.info.magazine;
    res.page_number = {(head.info.magazine == 3'd0) ? MAG_EIGHT : {1'b0, head.info.magazine},
                       head.info.page_units};
    res.page_units  = head.info.page_units;
    res.subpage     = head.info.subpage;
    res.page_flags  = head.info.page_flags;
    res.language    = head.info.language;
    final_word      = 1'b1;
    unique case (head.op)
      OP_END: begin
        res.kind = KIND_END;
      end
      OP_DATA: begin
        res.kind      = KIND_ROW;
        res.row       = head.row;
        res.column    = head.column;
        res.data_byte = head.data_byte;
      end
      OP_HDR: begin
        if (seq == '0) begin
          res.kind   = KIND_START;
          final_word = !head.kept;
        end else begin
          res.kind      = KIND_ROW;
          res.column    = 6'(idx);
          res.data_byte = head.hdr[idx];
          final_word    = (seq == SEQ_W'(HDR_BYTES));
        end
      end
      default: begin
        res.kind = KIND_END;
      end
    endcase
    res.last = final_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seq       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        seq       <= final_word ? '0 : seq + 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule
